/* design/rg32_pkg.sv */
// Shared constants and controller-to-datapath command type for the RadioGatun[32] engine.
package rg32_pkg;

    localparam int MILL_LEN     = 19;
    localparam int BELT_COLS    = 13;
    localparam int BELT_ROWS    = 3;
    localparam int BLANK_ROUNDS = 16;
    localparam int OUT_ROUNDS   = 4;
    localparam int CNT_W        = $clog2(BLANK_ROUNDS);

    typedef struct packed {
        logic absorb;    // xor the input word into belt and mill
        logic round;     // run one belt-mill round
        logic load_out;  // capture mill words 1 and 2 into the output register
        logic out_last;  // this capture is the last digest pair
        logic clear;     // return mill and belt to zero
    } rg32_cmd_t;

endpackage

/* design/rg32_datapath.sv */
// Mill, belt, input padding and digest output register of the RadioGatun[32] engine.
module rg32_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  rg32_pkg::rg32_cmd_t cmd,
    input  logic [31:0]         block_word0,
    input  logic [31:0]         block_word1,
    input  logic [31:0]         block_word2,
    input  logic                final_block,
    input  logic [3:0]          valid_bytes,
    output logic [31:0]         digest_lo_word,
    output logic [31:0]         digest_hi_word,
    output logic                digest_end
);
    import rg32_pkg::*;

    localparam int BLK_BYTES = 4 * BELT_ROWS;
    localparam logic [3:0] MAX_VALID = 4'(BLK_BYTES - 1);
    localparam logic [7:0] PAD_BYTE  = 8'h01;
    localparam int ROT [MILL_LEN] = '{0, 1, 3, 6, 10, 15, 21, 28, 4, 13, 23, 2, 14, 27, 9,
                                      24, 8, 25, 11};

    logic [31:0] mill_reg  [MILL_LEN];
    logic [31:0] mill_in   [MILL_LEN];
    logic [31:0] mill_t    [MILL_LEN];
    logic [31:0] mill_next [MILL_LEN];
    logic [31:0] belt_reg  [BELT_ROWS][BELT_COLS];
    logic [31:0] belt_in   [BELT_ROWS][BELT_COLS];
    logic [31:0] belt_x    [BELT_ROWS][BELT_COLS];
    logic [31:0] belt_next [BELT_ROWS][BELT_COLS];

    logic [8*BLK_BYTES-1:0] blk_raw;
    logic [8*BLK_BYTES-1:0] blk_pad;
    logic [31:0]            w [BELT_ROWS];
    logic [3:0]             nbytes;

    logic [31:0] digest_lo_reg;
    logic [31:0] digest_hi_reg;
    logic        digest_end_reg;

    // padding of the final block: keep bytes below the count, pad byte at the count, zero above
    assign blk_raw = {block_word2, block_word1, block_word0};
    assign nbytes  = (valid_bytes > MAX_VALID) ? MAX_VALID : valid_bytes;

    for (genvar k = 0; k < BLK_BYTES; k++) begin : g_pad
        assign blk_pad[8*k +: 8] = (!final_block || (4'(k) < nbytes)) ? blk_raw[8*k +: 8] :
                                   (4'(k) == nbytes) ? PAD_BYTE : 8'h00;
    end

    for (genvar r = 0; r < BELT_ROWS; r++) begin : g_word
        assign w[r] = blk_pad[32*r +: 32];
    end

    // absorb into logical column 0 and mill words 16..18
    for (genvar i = 0; i < MILL_LEN; i++) begin : g_mill_in
        if (i >= MILL_LEN - BELT_ROWS) begin : g_abs
            assign mill_in[i] = cmd.absorb ? (mill_reg[i] ^ w[i-(MILL_LEN-BELT_ROWS)])
                                           : mill_reg[i];
        end
        else begin : g_pass
            assign mill_in[i] = mill_reg[i];
        end
    end

    // belt is kept in logical order; the offset rotation becomes a column shift
    for (genvar r = 0; r < BELT_ROWS; r++) begin : g_belt_r
        for (genvar c = 0; c < BELT_COLS; c++) begin : g_belt_c
            localparam bit HIT = (c < BELT_COLS - 1) && ((c % BELT_ROWS) == r);
            if (c == 0) begin : g_c0
                assign belt_in[r][c] = cmd.absorb ? (belt_reg[r][c] ^ w[r]) : belt_reg[r][c];
            end
            else begin : g_cn
                assign belt_in[r][c] = belt_reg[r][c];
            end
            if (HIT) begin : g_feed
                assign belt_x[r][c] = belt_in[r][c] ^ mill_in[c+1];
            end
            else begin : g_keep
                assign belt_x[r][c] = belt_in[r][c];
            end
            if (c == 0) begin : g_wrap
                assign belt_next[r][c] = belt_x[r][BELT_COLS-1];
            end
            else begin : g_shift
                assign belt_next[r][c] = belt_x[r][c-1];
            end
        end
    end

    // mill: gamma, pi and theta, then iota and the belt feedback
    for (genvar i = 0; i < MILL_LEN; i++) begin : g_gamma
        localparam int J  = (7 * i) % MILL_LEN;
        localparam int J1 = (J + 1) % MILL_LEN;
        localparam int J2 = (J + 2) % MILL_LEN;
        localparam int R  = ROT[i];
        logic [31:0] x;
        logic [63:0] dbl;
        assign x         = mill_in[J] ^ (mill_in[J1] | ~mill_in[J2]);
        assign dbl       = {x, x};
        assign mill_t[i] = dbl[R +: 32];
    end

    for (genvar i = 0; i < MILL_LEN; i++) begin : g_theta
        localparam int I1 = (i + 1) % MILL_LEN;
        localparam int I4 = (i + 4) % MILL_LEN;
        logic [31:0] mix;
        assign mix = mill_t[i] ^ mill_t[I1] ^ mill_t[I4];
        if (i == 0) begin : g_iota
            assign mill_next[i] = mix ^ 32'h1;
        end
        else if ((i >= BELT_COLS) && (i < BELT_COLS + BELT_ROWS)) begin : g_fb
            assign mill_next[i] = mix ^ belt_in[i-BELT_COLS][BELT_COLS-1];
        end
        else begin : g_plain
            assign mill_next[i] = mix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MILL_LEN; i++)
            begin
                mill_reg[i] <= '0;
            end
            for (int r = 0; r < BELT_ROWS; r++)
            begin
                for (int c = 0; c < BELT_COLS; c++)
                begin
                    belt_reg[r][c] <= '0;
                end
            end
        end
        else if (cmd.clear)
        begin
            for (int i = 0; i < MILL_LEN; i++)
            begin
                mill_reg[i] <= '0;
            end
            for (int r = 0; r < BELT_ROWS; r++)
            begin
                for (int c = 0; c < BELT_COLS; c++)
                begin
                    belt_reg[r][c] <= '0;
                end
            end
        end
        else if (cmd.round)
        begin
            mill_reg  <= mill_next;
            belt_reg  <= belt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            digest_lo_reg  <= mill_next[1];
            digest_hi_reg  <= mill_next[2];
            digest_end_reg <= cmd.out_last;
        end
    end

    assign digest_lo_word = digest_lo_reg;
    assign digest_hi_word = digest_hi_reg;
    assign digest_end     = digest_end_reg;

endmodule

/* design/rg32_ctrl.sv */
// Round sequencer and output handshake control for the RadioGatun[32] engine.
module rg32_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                final_block,
    input  logic                out_stall,
    output logic                in_stall,
    output logic                out_valid,
    output rg32_pkg::rg32_cmd_t cmd
);
    import rg32_pkg::*;

    typedef enum logic [1:0] {
        ST_ABSORB,
        ST_BLANK,
        ST_OUTPUT
    } state_t;

    state_t           state_reg,     state_next;
    logic [CNT_W-1:0] cnt_reg,       cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        out_valid_next = (out_valid_reg && !out_stall) ? 1'b0 : out_valid_reg;
        unique case (state_reg)
            ST_ABSORB:
            begin
                if (in_valid)
                begin
                    cmd.absorb = 1'b1;
                    cmd.round  = 1'b1;
                    if (final_block)
                    begin
                        state_next = ST_BLANK;
                        cnt_next   = '0;
                    end
                end
            end
            ST_BLANK:
            begin
                cmd.round = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(BLANK_ROUNDS - 1))
                begin
                    state_next = ST_OUTPUT;
                    cnt_next   = '0;
                end
            end
            ST_OUTPUT:
            begin
                if (out_free)
                begin
                    cmd.round      = 1'b1;
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    cnt_next       = cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(OUT_ROUNDS - 1))
                    begin
                        cmd.out_last = 1'b1;
                        cmd.clear    = 1'b1;
                        state_next   = ST_ABSORB;
                        cnt_next     = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_ABSORB;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ABSORB;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_ABSORB);
    assign out_valid = out_valid_reg;

endmodule

/* design/radiogatun32_hash_top.sv */
// Top level of the RadioGatun[32] hash engine: sequencer plus mill/belt datapath.
//
// Input channel (in_valid / in_stall): one 12-byte message block per word, three
// little-endian 32-bit words. final_block marks the last block; valid_bytes
// (0..11, larger values read as 11) gives its message bytes and the pad byte
// follows them. A message whose length is a multiple of 12 ends with an extra
// final word of count 0.
// Output channel (out_valid / out_stall): four digest pairs per message, mill
// words 1 and 2 after each output round; digest_end marks the fourth pair.
// Sequence: a non-final word takes one belt-mill round. A final word takes the
// absorb round, 16 blank rounds and 4 output rounds. The first digest pair is
// captured in the first output round and is registered; the others follow one
// a cycle while the receiver does not stall. in_stall stays high from the final
// word until the last output round has run; the round datapath sets the rate.
// A stalled receiver holds the output register and pauses the output rounds.
// Reset clears mill, belt and sequencer; the engine clears itself again after
// each digest, so the next word starts a new message.
module radiogatun32_hash_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] block_word0,
    input  logic [31:0] block_word1,
    input  logic [31:0] block_word2,
    input  logic        final_block,
    input  logic [3:0]  valid_bytes,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_lo_word,
    output logic [31:0] digest_hi_word,
    output logic        digest_end
);
    import rg32_pkg::*;

    rg32_cmd_t cmd;

    rg32_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .final_block (final_block),
        .out_stall   (out_stall),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .cmd         (cmd)
    );

    rg32_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .block_word0    (block_word0),
        .block_word1    (block_word1),
        .block_word2    (block_word2),
        .final_block    (final_block),
        .valid_bytes    (valid_bytes),
        .digest_lo_word (digest_lo_word),
        .digest_hi_word (digest_hi_word),
        .digest_end     (digest_end)
    );

    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> (cmd.load_out && cmd.out_last))
        else $error("state cleared outside the last output round");

    a_no_absorb_in_output: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> !cmd.load_out)
        else $error("input word taken during an output round");

    a_load_shows_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid)
        else $error("digest pair loaded but not presented");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !cmd.load_out)
        else $error("output register overwritten while stalled");

endmodule
